/* src/fpa_pkg.sv */
`default_nettype none
package fpa_pkg;
  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned OpW = 4;
  localparam int unsigned IoW = 32;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_LT = 4'd4, OP_GT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_e;

  typedef struct packed {
    logic [IoW-1:0] value;
    logic           cmp;
    logic           dz;
    logic           sat;
  } res_t;
endpackage
`default_nettype wire

/* src/fpa_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per stage, fully pipelined.
// Computes q = floor(num / den) with num < 2^NumW, den < 2^DenW.
module fpa_div #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 33,
  parameter int unsigned TagW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic                 valid_o,
  output logic [NumW-1:0]      quot_o,
  output logic [TagW-1:0]      tag_o
);
  localparam int unsigned RemW = DenW + 1;

  logic [NumW:1]          vld_q;
  logic [NumW-1:0]        num_q [1:NumW];
  logic [RemW-1:0]        rem_q [1:NumW];
  logic [DenW-1:0]        den_q [1:NumW];
  logic [TagW-1:0]        tag_q [1:NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic            vld_c;
    logic [NumW-1:0] num_c;
    logic [RemW-1:0] rem_c;
    logic [DenW-1:0] den_c;
    logic [TagW-1:0] tag_c;
    logic [RemW-1:0] trial;
    logic [RemW:0]   diff;
    if (s == 0) begin : g_first
      assign vld_c = valid_i;
      assign num_c = num_i;
      assign rem_c = '0;
      assign den_c = den_i;
      assign tag_c = tag_i;
    end else begin : g_next
      assign vld_c = vld_q[s];
      assign num_c = num_q[s];
      assign rem_c = rem_q[s];
      assign den_c = den_q[s];
      assign tag_c = tag_q[s];
    end
    always_comb begin
      trial = {rem_c[RemW-2:0], num_c[NumW-1]};
      diff  = {1'b0, trial} - {2'b00, den_c};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_c;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= diff[RemW] ? trial : diff[RemW-1:0];
        num_q[s+1] <= {num_c[NumW-2:0], ~diff[RemW]};
        den_q[s+1] <= den_c;
        tag_q[s+1] <= tag_c;
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quot_o  = num_q[NumW];
  assign tag_o   = tag_q[NumW];
endmodule
`default_nettype wire

/* src/fixed_point_alu_q24_8.sv */
`default_nettype none
// Signed Q24.8 fixed-point ALU.
// s_axis: tdata = {operand_b, operand_a, opcode}, padded.
// m_axis: tdata = {saturated, divide_by_zero, compare_true, result_value}.
// One result transfer per input transfer, in order.
// Every operation passes the same pipeline: an operand stage, a multiply
// stage, a rounding stage, the divider (one stage per quotient bit,
// 2*FRAC_BITS+32 bits, 48 at defaults), a sign/saturate stage and the
// output register. Throughput is one transfer per cycle while
// s_axis_tready is high; the divider stages set the depth. A receiver
// stall freezes the whole pipeline once the skid entry fills; a two-entry
// skid buffer at the output keeps s_axis_tready registered, so nothing is
// lost or repeated. Reset clears all valid bits and the skid buffer; payloads are not reset.
module fixed_point_alu_q24_8 #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDef,
  parameter int unsigned WORD_BITS = fpa_pkg::WordBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // opcode[3:0], operand_a[35:4], operand_b[67:36]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // result_value[31:0], compare_true, divide_by_zero,
                                           // saturated, zeros
);
  import fpa_pkg::*;

  localparam int unsigned XW   = IoW + 2;                 // ext operand width
  localparam int unsigned PW   = 2 * IoW + 2;             // product / work width
  localparam int unsigned NumW = IoW + 2 * FRAC_BITS;     // 2*|a|*2^F + |b| < 2^NumW
  localparam int unsigned DenW = IoW + 2;                 // 2*|b|
  localparam int unsigned TagW = OpW + 3 + PW;

  // ---------------- stage 1: operands ----------------
  logic en;
  logic            v1_q;
  op_e             op1_q;
  logic signed [XW-1:0] a1_q, b1_q;

  logic signed [IoW-1:0] a_in, b_in;
  always_comb begin
    a_in = $signed(s_axis_tdata[35:4]);
    b_in = $signed(s_axis_tdata[67:36]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid && s_axis_tready;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= op_e'(s_axis_tdata[3:0]);
      a1_q  <= XW'(a_in);
      b1_q  <= XW'(b_in);
    end
  end

  // ---------------- stage 2: multiply, simple ops, divider setup -------
  logic signed [PW-1:0]    simple_d, prod_d;
  logic signed [2*IoW-1:0] prod_n;
  logic                    cmp_d;
  logic                    a_neg, b_neg;
  logic [XW-1:0]           a_mag, b_mag;
  always_comb begin
    a_neg = a1_q[XW-1];
    b_neg = b1_q[XW-1];
    a_mag = a_neg ? XW'(-a1_q) : XW'(a1_q);
    b_mag = b_neg ? XW'(-b1_q) : XW'(b1_q);
    prod_n   = $signed(a1_q[IoW-1:0]) * $signed(b1_q[IoW-1:0]);
    prod_d   = PW'(prod_n);
    simple_d = '0;
    cmp_d    = 1'b0;
    case (op1_q)
      OP_ADD:      simple_d = PW'(a1_q) + PW'(b1_q);
      OP_SUB:      simple_d = PW'(a1_q) - PW'(b1_q);
      OP_LT:       cmp_d = a1_q <  b1_q;
      OP_GT:       cmp_d = a1_q >  b1_q;
      OP_LE:       cmp_d = a1_q <= b1_q;
      OP_GE:       cmp_d = a1_q >= b1_q;
      OP_EQ:       cmp_d = a1_q == b1_q;
      OP_NE:       cmp_d = a1_q != b1_q;
      OP_MIN:      simple_d = PW'((a1_q < b1_q) ? a1_q : b1_q);
      OP_MAX:      simple_d = PW'((a1_q > b1_q) ? a1_q : b1_q);
      OP_INC:      simple_d = PW'(a1_q) + PW'(1);
      OP_DEC:      simple_d = PW'(a1_q) - PW'(1);
      OP_FROM_INT: simple_d = PW'(a1_q) <<< FRAC_BITS;
      OP_TO_INT:   simple_d = PW'(a1_q) >>> FRAC_BITS;
      default:     simple_d = '0;
    endcase
  end

  logic                 v2_q;
  op_e                  op2_q;
  logic signed [PW-1:0] val2_q;
  logic                 cmp2_q, neg2_q, dz2_q;
  logic [NumW-1:0]      num2_q;
  logic [DenW-1:0]      den2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q  <= op1_q;
      val2_q <= (op1_q == OP_MUL) ? prod_d : simple_d;
      cmp2_q <= cmp_d;
      neg2_q <= a_neg ^ b_neg;
      dz2_q  <= (b1_q == '0);
      // 2*num + den over 2*den, num = |a|<<F
      num2_q <= (NumW'(a_mag) << (FRAC_BITS + 1)) + NumW'(b_mag);
      den2_q <= DenW'(b_mag) << 1;
    end
  end

  // ---------------- stage 3: mul rounding magnitude ----------------
  logic                 v3_q;
  op_e                  op3_q;
  logic signed [PW-1:0] val3_q;
  logic                 cmp3_q, neg3_q, dz3_q;
  logic [NumW-1:0]      num3_q;
  logic [DenW-1:0]      den3_q;
  logic [PW-1:0]        pmag;
  logic                 pneg;
  always_comb begin
    pneg = val2_q[PW-1];
    pmag = pneg ? PW'(-val2_q) : PW'(val2_q);
    pmag = (pmag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      op3_q  <= op2_q;
      val3_q <= (op2_q == OP_MUL) ? (pneg ? PW'(-$signed(pmag)) : $signed(pmag)) : val2_q;
      cmp3_q <= cmp2_q;
      neg3_q <= neg2_q;
      dz3_q  <= dz2_q;
      num3_q <= num2_q;
      den3_q <= dz2_q ? DenW'(1) : den2_q;
    end
  end

  // ---------------- divider pipeline ----------------
  logic            vd;
  logic [NumW-1:0] quot;
  logic [TagW-1:0] tag_in, tag_out;
  assign tag_in = {op3_q, cmp3_q, neg3_q, dz3_q, val3_q};

  fpa_div #(.NumW(NumW), .DenW(DenW), .TagW(TagW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (num3_q),
    .den_i   (den3_q),
    .tag_i   (tag_in),
    .valid_o (vd),
    .quot_o  (quot),
    .tag_o   (tag_out)
  );

  // ---------------- final stage: sign, saturate, pack ----------------
  op_e                  opf;
  logic                 cmpf, negf, dzf, satf;
  logic signed [PW-1:0] valf, wide;
  logic signed [PW-1:0] maxv, minv;
  res_t                 res_d;
  always_comb begin
    opf  = op_e'(tag_out[TagW-1 -: OpW]);
    cmpf = tag_out[PW+2];
    negf = tag_out[PW+1];
    dzf  = tag_out[PW];
    valf = $signed(tag_out[PW-1:0]);
    maxv = PW'((PW'(1) << (WORD_BITS - 1)) - PW'(1));
    minv = -maxv - PW'(1);
    wide = valf;
    if (opf == OP_DIV) begin
      wide = negf ? -$signed(PW'(quot)) : $signed(PW'(quot));
    end
    satf = 1'b0;
    res_d.value = '0;
    if (wide > maxv) begin
      satf = 1'b1;
      wide = maxv;
    end else if (wide < minv) begin
      satf = 1'b1;
      wide = minv;
    end
    res_d.value = wide[IoW-1:0];
    res_d.cmp   = cmpf;
    res_d.dz    = 1'b0;
    res_d.sat   = satf;
    if (opf == OP_DIV && dzf) begin
      res_d.value = '0;
      res_d.dz    = 1'b1;
      res_d.sat   = 1'b0;
    end
  end

  logic vf_q;
  res_t resf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (en) vf_q <= vd;
  end
  always_ff @(posedge clk_i) begin
    if (en) resf_q <= res_d;
  end

  // ---------------- output skid buffer ----------------
  logic main_v_q, skid_v_q;
  res_t main_q, skid_q;
  assign en            = !skid_v_q;
  assign s_axis_tready = !skid_v_q;
  assign m_axis_tvalid = main_v_q;
  assign m_axis_tdata  = {5'd0, main_q.sat, main_q.dz, main_q.cmp, main_q.value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!main_v_q || m_axis_tready) begin
        main_v_q <= skid_v_q ? 1'b1 : (en && vf_q);
        skid_v_q <= 1'b0;
      end else if (en && vf_q) begin
        skid_v_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (!main_v_q || m_axis_tready) begin
      main_q <= skid_v_q ? skid_q : resf_q;
    end else if (en && vf_q) begin
      skid_q <= resf_q;
    end
  end
endmodule
`default_nettype wire

/* src/fpa_checker.sv */
`default_nettype none
module fpa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[31:0] == '0 && !m_axis_tdata[34])
    else $error("div by zero result not clean");
  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == '0 && !m_axis_tdata[34]
      && !m_axis_tdata[33])
    else $error("compare result carries value");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:35] == '0)
    else $error("padding not zero");
endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
